>>> rtl/core/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the stereo block-match disparity core.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Coordinate width: holds frame sizes up to 127 plus window reach and offset.
  localparam int CoordW     = 8;
  localparam int OffW       = 6;
  localparam int PixW       = 8;
  localparam int TermW      = 2 * PixW;
  localparam int CostW      = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 7;
  localparam int MaxOffset  = 63;
  localparam int DepthScale = 3;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_METRIC   = 3'd0,
    REG_REF_SIDE = 3'd1,
    REG_MAX_DISP = 3'd2,
    REG_HALF_WIN = 3'd3,
    REG_FRAME_W  = 3'd4,
    REG_FRAME_H  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    METRIC_SSD = 1'b0,
    METRIC_SAD = 1'b1
  } metric_e;

  typedef enum logic {
    REF_LEFT  = 1'b0,
    REF_RIGHT = 1'b1
  } ref_side_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } sbm_state_e;

  typedef struct packed {
    metric_e     metric;
    ref_side_e   ref_side;
    logic [5:0]  max_disparity;
    logic [2:0]  half_window;
    logic [6:0]  frame_width;
    logic [6:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [5:0]  pos_x;
    logic [5:0]  pos_y;
    logic [7:0]  left_pixel;
    logic [7:0]  right_pixel;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  disparity;
    logic [7:0]  depth_byte;
    logic [23:0] best_cost;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic store;
    logic load;
    logic step;
    logic publish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_store;
    logic query_hit;
    logic last_issue;
    logic busy;
    logic out_full;
  } dp_status_t;

endpackage

>>> rtl/core/sbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbm_cfg_regs
// Configuration register file, written through an index/data port.
// ----------------------------------------------------------------------------
module sbm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbm_pkg::CfgDataW-1:0]  cfg_data_i,
  output sbm_pkg::cfg_t                 cfg_o
);

  sbm_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.metric        <= sbm_pkg::METRIC_SSD;
      cfg_q.ref_side      <= sbm_pkg::REF_LEFT;
      cfg_q.max_disparity <= 6'd16;
      cfg_q.half_window   <= 3'd2;
      cfg_q.frame_width   <= 7'd64;
      cfg_q.frame_height  <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sbm_pkg::cfg_reg_e'(cfg_index_i))
        sbm_pkg::REG_METRIC:   cfg_q.metric        <= sbm_pkg::metric_e'(cfg_data_i[0]);
        sbm_pkg::REG_REF_SIDE: cfg_q.ref_side      <= sbm_pkg::ref_side_e'(cfg_data_i[0]);
        sbm_pkg::REG_MAX_DISP: cfg_q.max_disparity <= cfg_data_i[5:0];
        sbm_pkg::REG_HALF_WIN: cfg_q.half_window   <= cfg_data_i[2:0];
        sbm_pkg::REG_FRAME_W:  cfg_q.frame_width   <= cfg_data_i[6:0];
        sbm_pkg::REG_FRAME_H:  cfg_q.frame_height  <= cfg_data_i[6:0];
        default: ; // unknown index: ignored
      endcase
    end
  end

endmodule

>>> rtl/core/sbm_frame_mem.sv
// ----------------------------------------------------------------------------
// sbm_frame_mem
// One grey frame: single write port, single registered read port.
// ----------------------------------------------------------------------------
module sbm_frame_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [sbm_pkg::PixW-1:0]    wdata_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [sbm_pkg::PixW-1:0]    rdata_o
);

  logic [sbm_pkg::PixW-1:0] mem_q [DEPTH];
  logic [sbm_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: takes requests, runs the offset/window sweep, publishes results.
// ----------------------------------------------------------------------------
module sbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbm_pkg::dp_status_t  status_i,
  output sbm_pkg::ctrl_cmd_t   cmd_o
);

  sbm_pkg::sbm_state_e state_q, state_d;
  logic                accept;

  assign in_stall_o = (state_q != sbm_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbm_pkg::ST_IDLE: begin
        if (accept && status_i.query_hit) begin
          state_d = sbm_pkg::ST_SWEEP;
        end
      end
      sbm_pkg::ST_SWEEP: begin
        if (status_i.last_issue) begin
          state_d = sbm_pkg::ST_DRAIN;
        end
      end
      sbm_pkg::ST_DRAIN: begin
        if (!status_i.busy && !status_i.out_full) begin
          state_d = sbm_pkg::ST_IDLE;
        end
      end
      default: state_d = sbm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      sbm_pkg::ST_IDLE: begin
        cmd_o.store = accept && status_i.is_store;
        cmd_o.load  = accept && status_i.query_hit;
      end
      sbm_pkg::ST_SWEEP: begin
        cmd_o.step = 1'b1;
      end
      sbm_pkg::ST_DRAIN: begin
        cmd_o.publish = !status_i.busy && !status_i.out_full;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/core/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath
// Window scan counters, frame memories, difference/accumulate pipeline,
// best-offset tracker and output register.
// ----------------------------------------------------------------------------
module sbm_datapath #(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbm_pkg::cfg_t        cfg_i,
  input  sbm_pkg::in_item_t    in_item_i,
  input  sbm_pkg::ctrl_cmd_t   cmd_i,
  output sbm_pkg::dp_status_t  status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output sbm_pkg::out_item_t   out_item_o
);

  localparam int CW      = sbm_pkg::CoordW;
  localparam int OW      = sbm_pkg::OffW;
  localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WinSide = 2 * MAX_HALF_WINDOW + 1;
  localparam int MaxCost = WinSide * WinSide * 255 * 255;
  localparam int AccW    = $clog2(MaxCost + 1);

  function automatic logic [AddrW-1:0] addr_of(input logic [CW-1:0] col,
                                               input logic [CW-1:0] row);
    addr_of = AddrW'(32'(row) * MAX_WIDTH + 32'(col));
  endfunction

  // ---- effective settings (clamped)
  logic [CW-1:0] width_eff, height_eff, half_eff;
  logic [OW-1:0] maxd_eff;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      width_eff = CW'(1);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      height_eff = CW'(1);
    end else if (32'(cfg_i.frame_height) > MAX_HEIGHT) begin
      height_eff = CW'(MAX_HEIGHT);
    end else begin
      height_eff = CW'(cfg_i.frame_height);
    end
    if (32'(cfg_i.half_window) > MAX_HALF_WINDOW) begin
      half_eff = CW'(MAX_HALF_WINDOW);
    end else begin
      half_eff = CW'(cfg_i.half_window);
    end
    if (32'(cfg_i.max_disparity) > sbm_pkg::MaxOffset) begin
      maxd_eff = OW'(sbm_pkg::MaxOffset);
    end else begin
      maxd_eff = cfg_i.max_disparity;
    end
  end

  // ---- request decode and window bounds
  logic [CW-1:0] qx, qy, bx0, bx1, by0, by1;
  logic          st_in_range;

  assign qx = CW'(in_item_i.pos_x);
  assign qy = CW'(in_item_i.pos_y);
  assign st_in_range = (32'(in_item_i.pos_x) < MAX_WIDTH) &&
                       (32'(in_item_i.pos_y) < MAX_HEIGHT);

  always_comb begin
    bx0 = (qx > half_eff) ? qx - half_eff : '0;
    by0 = (qy > half_eff) ? qy - half_eff : '0;
    bx1 = (qx + half_eff < width_eff)  ? qx + half_eff : width_eff - CW'(1);
    by1 = (qy + half_eff < height_eff) ? qy + half_eff : height_eff - CW'(1);
  end

  // ---- scan counters (issue stage)
  logic [CW-1:0] wx_q, wy_q, x0_q, x1_q, y0_q, y1_q;
  logic [OW-1:0] off_q;
  logic          last_issue, first_issue, win_last;

  // win_last: last pixel of the current offset's window
  assign win_last    = (wx_q == x1_q) && (wy_q == y1_q);
  assign last_issue  = win_last && (off_q == maxd_eff);
  assign first_issue = (wx_q == x0_q) && (wy_q == y0_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q  <= bx0;
      x1_q  <= bx1;
      y0_q  <= by0;
      y1_q  <= by1;
      wx_q  <= bx0;
      wy_q  <= by0;
      off_q <= '0;
    end else if (cmd_i.step) begin
      if (wx_q != x1_q) begin
        wx_q <= wx_q + CW'(1);
      end else begin
        wx_q <= x0_q;
        if (wy_q != y1_q) begin
          wy_q <= wy_q + CW'(1);
        end else begin
          wy_q  <= y0_q;
          off_q <= off_q + OW'(1);
        end
      end
    end
  end

  // shifted column of the non-reference frame
  logic [CW-1:0]    off_c, sh_col;
  logic [AddrW-1:0] ref_addr, oth_addr;

  assign off_c = CW'(off_q);

  always_comb begin
    if (cfg_i.ref_side == sbm_pkg::REF_LEFT) begin
      sh_col = (wx_q < off_c) ? wx_q : wx_q - off_c;
    end else begin
      sh_col = ((off_c < width_eff) && (wx_q < width_eff - off_c)) ? wx_q + off_c : wx_q;
    end
  end

  assign ref_addr = addr_of(wx_q, wy_q);
  assign oth_addr = addr_of(sh_col, wy_q);

  // ---- stage 1: read addresses (last1..3 flag the end of each window)
  logic [AddrW-1:0] lra_q, rra_q;
  logic             v1_q, first1_q, last1_q;
  logic [OW-1:0]    off1_q;

  always_ff @(posedge clk_i) begin
    if (cfg_i.ref_side == sbm_pkg::REF_LEFT) begin
      lra_q <= ref_addr;
      rra_q <= oth_addr;
    end else begin
      lra_q <= oth_addr;
      rra_q <= ref_addr;
    end
    first1_q <= first_issue;
    last1_q  <= win_last;
    off1_q   <= off_q;
  end

  // ---- frame memories (stage 2 data)
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [sbm_pkg::PixW-1:0] l_rd, r_rd;

  assign mem_we    = cmd_i.store && st_in_range;
  assign mem_waddr = addr_of(qx, qy);

  sbm_frame_mem #(.DEPTH(Depth), .ADDR_W(AddrW)) u_left_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_item_i.left_pixel),
    .raddr_i (lra_q),
    .rdata_o (l_rd)
  );

  sbm_frame_mem #(.DEPTH(Depth), .ADDR_W(AddrW)) u_right_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_item_i.right_pixel),
    .raddr_i (rra_q),
    .rdata_o (r_rd)
  );

  logic          v2_q, first2_q, last2_q;
  logic [OW-1:0] off2_q;

  always_ff @(posedge clk_i) begin
    first2_q <= first1_q;
    last2_q  <= last1_q;
    off2_q   <= off1_q;
  end

  // ---- stage 3: difference and term
  logic [sbm_pkg::PixW-1:0]  ref_pix, oth_pix, diff;
  logic [sbm_pkg::TermW-1:0] term;
  logic [sbm_pkg::TermW-1:0] term3_q;
  logic                      v3_q, first3_q, last3_q;
  logic [OW-1:0]             off3_q;

  always_comb begin
    ref_pix = (cfg_i.ref_side == sbm_pkg::REF_LEFT) ? l_rd : r_rd;
    oth_pix = (cfg_i.ref_side == sbm_pkg::REF_LEFT) ? r_rd : l_rd;
    diff    = (ref_pix > oth_pix) ? ref_pix - oth_pix : oth_pix - ref_pix;
    if (cfg_i.metric == sbm_pkg::METRIC_SSD) begin
      term = sbm_pkg::TermW'(diff) * sbm_pkg::TermW'(diff);
    end else begin
      term = sbm_pkg::TermW'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    term3_q  <= term;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    off3_q   <= off2_q;
  end

  // ---- stage 4: window accumulate
  logic [AccW-1:0] acc_q, acc_sum, cost_q;
  logic            cv_q;
  logic [OW-1:0]   coff_q;

  assign acc_sum = (first3_q ? '0 : acc_q) + AccW'(term3_q);

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      acc_q <= acc_sum;
    end
    cost_q <= acc_sum;
    coff_q <= off3_q;
  end

  // ---- stage 5: best offset, first minimum wins
  logic [AccW-1:0] best_q;
  logic [OW-1:0]   best_off_q;

  always_ff @(posedge clk_i) begin
    if (cv_q && ((coff_q == '0) || (cost_q < best_q))) begin
      best_q     <= cost_q;
      best_off_q <= coff_q;
    end
  end

  // ---- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      cv_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
      v3_q <= v2_q;
      cv_q <= v3_q && last3_q;
    end
  end

  // ---- output register
  logic               out_valid_q;
  sbm_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.disparity  <= best_off_q;
      out_q.depth_byte <= 8'(8'(best_off_q) * 8'(sbm_pkg::DepthScale));
      out_q.best_cost  <= (32'(best_q) > 32'(sbm_pkg::CostMax)) ?
                          sbm_pkg::CostMax : sbm_pkg::CostW'(best_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- status
  assign status_o.is_store   = (in_item_i.command == sbm_pkg::CMD_STORE);
  assign status_o.query_hit  = (in_item_i.command == sbm_pkg::CMD_QUERY) &&
                               (qx < width_eff) && (qy < height_eff);
  assign status_o.last_issue = last_issue;
  assign status_o.busy       = v1_q || v2_q || v3_q || cv_q;
  assign status_o.out_full   = out_valid_q;

endmodule

>>> rtl/core/stereo_block_match_disparity_core.sv
// ----------------------------------------------------------------------------
// stereo_block_match_disparity_core
// Block-matching disparity engine over two stored grey frames (SSD / SAD).
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (store or query)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (disparity, cost)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A query inside the frame is loaded, then sweeps every window pixel for
//  each offset 0..maxd (issue), then drains the cost pipeline and publishes;
//  the sweep issues one pixel pair per cycle through a single read port on
//  each frame memory. A query outside the active frame gives no result.
//  Reset clears the control state and valid bits and sets the configuration
//  registers to defaults; frame contents stay undefined until written.
//  While a query runs, in_stall_o is high. A result waiting in the output
//  register lets store requests through; the next query holds in its drain
//  state until the output register is free.
// ----------------------------------------------------------------------------
module stereo_block_match_disparity_core #(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sbm_pkg::in_item_t             in_item_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sbm_pkg::out_item_t            out_item_o,
  // register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbm_pkg::CfgDataW-1:0]  cfg_data_i
);

  sbm_pkg::cfg_t       cfg;
  sbm_pkg::ctrl_cmd_t  cmd;
  sbm_pkg::dp_status_t status;

  // registers
  sbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: idle / sweep / drain
  sbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // frames, scan counters, cost pipeline, output register
  sbm_datapath #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // ---- assertions

  // a result is published only once the cost pipeline has fully drained
  a_publish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !status.busy)
    else $error("publish with cost pipeline still busy");

  // a publish never overwrites a result that is still waiting
  a_publish_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !out_valid_o)
    else $error("publish over a pending result");

  // the sweep runs only while the request channel is stalled
  a_step_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> in_stall_o)
    else $error("window scan while requests are accepted");

  // a loaded query starts scanning on the next cycle
  a_load_then_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.step)
    else $error("query loaded but scan did not start");

endmodule
